// ----- hw/rtl/tdsc_pkg.sv -----
// Shared types, constants and tables for the tilt deadzone servo controller.
// Depends on nothing; every other file uses it.
`default_nettype none

package tdsc_pkg;

   // Calibration and CORDIC sizing.
   localparam int unsigned DiscardSamples = 30;
   localparam int unsigned CalSamples     = 150;
   localparam int unsigned CordicSteps    = 16;
   localparam int unsigned AtanLen        = 24;
   localparam int unsigned IterWidth      = $clog2(AtanLen);

   // Datapath widths.
   localparam int unsigned CordicWidth = 35;
   localparam int unsigned AccWidth    = 26;
   localparam int unsigned PitchWidth  = 17;
   localparam int unsigned SumWidth    = 24;
   localparam int unsigned CsrWidth    = 16;
   localparam int unsigned CsrIdxWidth = 3;

   // Angles in degrees Q16 and limits.
   localparam int signed   Q16Ninety  = 5898240;
   localparam int signed   PitchLimit = 46080;
   localparam int signed   SumLimit   = 8388607;
   localparam int unsigned Center     = 90;
   localparam int unsigned AngleLow   = 45;
   localparam int unsigned AngleHigh  = 135;

   // Division by a constant: floor(2^32 / divisor), then one correction step.
   localparam int unsigned DivServo   = 180;
   localparam int unsigned DivCal     = 150;
   localparam int unsigned RecipServo = 23860929;
   localparam int unsigned RecipCal   = 28633115;
   localparam int unsigned RecipWidth = 25;

   // Configuration register indexes.
   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_DEADZONE  = 3'd0,
      CSR_GAIN      = 3'd1,
      CSR_MAX_DELTA = 3'd2,
      CSR_MIN_STEP  = 3'd3,
      CSR_PULSE_MIN = 3'd4,
      CSR_PULSE_MAX = 3'd5,
      CSR_PERIOD    = 3'd6
   } csr_index_type;

   // Operating phase of the posture loop.
   typedef enum logic [1:0] {
      PH_DISCARD = 2'd0,
      PH_AVERAGE = 2'd1,
      PH_CONTROL = 2'd2
   } phase_type;

   // Controller states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ROTATE,
      ST_PITCH,
      ST_STEP,
      ST_CONTROL,
      ST_NDIV_MUL,
      ST_NDIV_FIX,
      ST_NSET,
      ST_CMP_MUL,
      ST_CDIV_MUL,
      ST_CDIV_FIX,
      ST_OUTPUT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic                 load;
      logic                 rotate;
      logic [IterWidth-1:0] iter;
      logic                 pitch_done;
      logic                 step;
      logic                 accumulate;
      logic                 control;
      logic                 div_mul;
      logic                 div_cal;
      logic                 div_fix;
      logic                 set_neutral;
      logic                 cmp_mul;
      logic                 out_load;
      logic                 calibrating;
   } dp_cmd_type;

   // atan(2^-i) in degrees Q16.
   function automatic logic [22:0] atan_q16(input logic [IterWidth-1:0] idx);
      logic [22:0] val;
      unique case (idx)
         5'd0:  val = 23'd2949120;
         5'd1:  val = 23'd1740967;
         5'd2:  val = 23'd919879;
         5'd3:  val = 23'd466945;
         5'd4:  val = 23'd234379;
         5'd5:  val = 23'd117304;
         5'd6:  val = 23'd58666;
         5'd7:  val = 23'd29335;
         5'd8:  val = 23'd14668;
         5'd9:  val = 23'd7334;
         5'd10: val = 23'd3667;
         5'd11: val = 23'd1833;
         5'd12: val = 23'd917;
         5'd13: val = 23'd458;
         5'd14: val = 23'd229;
         5'd15: val = 23'd115;
         5'd16: val = 23'd57;
         5'd17: val = 23'd29;
         5'd18: val = 23'd14;
         5'd19: val = 23'd7;
         5'd20: val = 23'd4;
         5'd21: val = 23'd2;
         5'd22: val = 23'd1;
         default: val = 23'd0;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/tdsc_if.sv -----
// Handshake channels for sample words and result words.
// Depends on tdsc_pkg for the pitch width.
`default_nettype none

interface tdsc_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] accel_y;
   logic signed [15:0] accel_z;
   modport source (output valid, output accel_y, output accel_z, input ready);
   modport sink   (input valid, input accel_y, input accel_z, output ready);
endinterface

interface tdsc_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [15:0]                          pulse_compare;
   logic                                 servo_update;
   logic                                 led_on;
   logic                                 calibrating;
   logic signed [tdsc_pkg::PitchWidth-1:0] pitch;
   modport source (output valid, output pulse_compare, output servo_update, output led_on,
                   output calibrating, output pitch, input ready);
   modport sink   (input valid, input pulse_compare, input servo_update, input led_on,
                   input calibrating, input pitch, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/tilt_deadzone_servo_controller_unit.sv -----
// Top level of the tilt deadzone servo controller.
// Depends on tdsc_pkg, tdsc_if, tdsc_ctrl and tdsc_dp.
//
//   channel | direction | word
//   req_ch  | in        | accel_y, accel_z
//   rsp_ch  | out       | pulse_compare, servo_update, led_on, calibrating, pitch
//   csr_*   | in        | write enable, index, 16-bit data
//
// One sample word is handled at a time: it passes the 16 CORDIC micro-rotations,
// the pitch and step states, the control law in a control step or the neutral divide
// on the step that closes calibration, then the compare multiply and the divide.
// Reset is synchronous and active high and restores the register defaults.
// A result waits in its register while the next sample is accepted; a stalled
// result holds the block only when the next one is ready to be written.
`default_nettype none

module tilt_deadzone_servo_controller_unit (
   input  wire logic                             clock,
   input  wire logic                             reset,
   tdsc_req_if.sink                              req_ch,
   tdsc_rsp_if.source                            rsp_ch,
   input  wire logic                             csr_we,
   input  wire logic [tdsc_pkg::CsrIdxWidth-1:0] csr_index,
   input  wire logic [tdsc_pkg::CsrWidth-1:0]    csr_wdata
);
   import tdsc_pkg::*;

   dp_cmd_type cmd;

   // Sequencer.
   tdsc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd)
   );

   // Arithmetic.
   tdsc_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .in_accel_y        (req_ch.accel_y),
      .in_accel_z        (req_ch.accel_z),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .out_pulse_compare (rsp_ch.pulse_compare),
      .out_servo_update  (rsp_ch.servo_update),
      .out_led_on        (rsp_ch.led_on),
      .out_calibrating   (rsp_ch.calibrating),
      .out_pitch         (rsp_ch.pitch)
   );

endmodule

`default_nettype wire

// ----- hw/rtl/tdsc_ctrl.sv -----
// Sequencer: phase and sample count, CORDIC iteration count, handshakes.
// Depends on tdsc_pkg; drives tdsc_dp through a command struct.
`default_nettype none

module tdsc_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output tdsc_pkg::dp_cmd_type      cmd
);
   import tdsc_pkg::*;

   state_type            state_ff, state_in;
   phase_type            phase_ff, phase_in;
   logic [7:0]           count_ff, count_in;
   logic [IterWidth-1:0] iter_ff, iter_in;
   logic                 cal_ff, cal_in;
   logic                 full_ff, full_in;
   logic [7:0]           count_next;

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PH_DISCARD;
         count_ff <= '0;
         iter_ff  <= '0;
         cal_ff   <= 1'b0;
         full_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         count_ff <= count_in;
         iter_ff  <= iter_in;
         cal_ff   <= cal_in;
         full_ff  <= full_in;
      end
   end

   assign count_next = count_ff + 8'd1;
   assign req_ready  = (state_ff == ST_IDLE);
   assign rsp_valid  = full_ff;

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      count_in = count_ff;
      iter_in  = iter_ff;
      cal_in   = cal_ff;
      full_in  = (full_ff && !rsp_ready);
      cmd      = '0;
      cmd.iter = iter_ff;
      cmd.calibrating = cal_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               iter_in  = '0;
               state_in = ST_ROTATE;
            end
         end
         ST_ROTATE: begin
            cmd.rotate = 1'b1;
            iter_in    = iter_ff + 1'b1;
            if (iter_ff == IterWidth'(CordicSteps - 1)) begin
               state_in = ST_PITCH;
            end
         end
         ST_PITCH: begin
            cmd.pitch_done = 1'b1;
            state_in       = ST_STEP;
         end
         ST_STEP: begin
            cmd.step = 1'b1;
            // The discard phase ends once enough samples were dropped.
            if (phase_ff == PH_DISCARD && count_ff >= 8'(DiscardSamples)) begin
               cmd.accumulate = 1'b1;
               cal_in         = 1'b1;
               count_in       = 8'd1;
               phase_in       = PH_AVERAGE;
               state_in       = ST_CMP_MUL;
               if (8'd1 >= 8'(CalSamples)) begin
                  phase_in = PH_CONTROL;
                  state_in = ST_NDIV_MUL;
               end
            end else begin
               priority case (phase_ff)
                  PH_DISCARD: begin
                     cal_in   = 1'b1;
                     count_in = count_next;
                     state_in = ST_CMP_MUL;
                  end
                  PH_AVERAGE: begin
                     cmd.accumulate = 1'b1;
                     cal_in         = 1'b1;
                     count_in       = count_next;
                     state_in       = ST_CMP_MUL;
                     if (count_next >= 8'(CalSamples) || count_next == 8'd0) begin
                        phase_in = PH_CONTROL;
                        state_in = ST_NDIV_MUL;
                     end
                  end
                  default: begin
                     cal_in   = 1'b0;
                     state_in = ST_CONTROL;
                  end
               endcase
            end
         end
         ST_CONTROL: begin
            cmd.control = 1'b1;
            state_in    = ST_CMP_MUL;
         end
         ST_NDIV_MUL: begin
            cmd.div_mul = 1'b1;
            cmd.div_cal = 1'b1;
            state_in    = ST_NDIV_FIX;
         end
         ST_NDIV_FIX: begin
            cmd.div_fix = 1'b1;
            cmd.div_cal = 1'b1;
            state_in    = ST_NSET;
         end
         ST_NSET: begin
            cmd.set_neutral = 1'b1;
            state_in        = ST_CMP_MUL;
         end
         ST_CMP_MUL: begin
            cmd.cmp_mul = 1'b1;
            state_in    = ST_CDIV_MUL;
         end
         ST_CDIV_MUL: begin
            cmd.div_mul = 1'b1;
            state_in    = ST_CDIV_FIX;
         end
         ST_CDIV_FIX: begin
            cmd.div_fix = 1'b1;
            state_in    = ST_OUTPUT;
         end
         ST_OUTPUT: begin
            // Hold until the result register is free.
            if (!full_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               full_in      = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- hw/rtl/tdsc_dp.sv -----
// Datapath: configuration registers, CORDIC, calibration sum, control law,
// shared divide-by-constant and PWM compare. Depends on tdsc_pkg.
`default_nettype none

module tdsc_dp (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire tdsc_pkg::dp_cmd_type                cmd,
   input  wire logic signed [15:0]                  in_accel_y,
   input  wire logic signed [15:0]                  in_accel_z,
   input  wire logic                                csr_we,
   input  wire logic [tdsc_pkg::CsrIdxWidth-1:0]    csr_index,
   input  wire logic [tdsc_pkg::CsrWidth-1:0]       csr_wdata,
   output logic [15:0]                              out_pulse_compare,
   output logic                                     out_servo_update,
   output logic                                     out_led_on,
   output logic                                     out_calibrating,
   output logic signed [tdsc_pkg::PitchWidth-1:0]   out_pitch
);
   import tdsc_pkg::*;

   // Configuration registers.
   logic [15:0] deadzone_ff, pmin_ff, pmax_ff, period_ff;
   logic [7:0]  gain_ff;
   logic [6:0]  max_delta_ff, min_step_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         deadzone_ff  <= 16'd3072;
         gain_ff      <= 8'd32;
         max_delta_ff <= 7'd40;
         min_step_ff  <= 7'd2;
         pmin_ff      <= 16'd200;
         pmax_ff      <= 16'd600;
         period_ff    <= 16'd5000;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_DEADZONE:  deadzone_ff  <= csr_wdata;
            CSR_GAIN:      gain_ff      <= csr_wdata[7:0];
            CSR_MAX_DELTA: max_delta_ff <= csr_wdata[6:0];
            CSR_MIN_STEP:  min_step_ff  <= csr_wdata[6:0];
            CSR_PULSE_MIN: pmin_ff      <= csr_wdata;
            CSR_PULSE_MAX: pmax_ff      <= csr_wdata;
            CSR_PERIOD:    period_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------- CORDIC ----------------
   logic signed [CordicWidth-1:0] x_ff, y_ff, x_in, y_in;
   logic signed [AccWidth-1:0]    acc_ff, acc_in;
   logic                          zero_ff;
   logic signed [CordicWidth-1:0] ay, az, sx, sy;
   logic signed [AccWidth-1:0]    atan_step;

   assign ay        = CordicWidth'(in_accel_y);
   assign az        = CordicWidth'(in_accel_z);
   assign sx        = y_ff >>> cmd.iter;
   assign sy        = x_ff >>> cmd.iter;
   assign atan_step = AccWidth'(atan_q16(cmd.iter));

   // Quadrant fold on load, then one micro-rotation per cycle.
   always_comb begin
      x_in   = x_ff;
      y_in   = y_ff;
      acc_in = acc_ff;
      if (cmd.load) begin
         if (az < 0) begin
            if (ay >= 0) begin
               x_in   = ay <<< 16;
               y_in   = (-az) <<< 16;
               acc_in = AccWidth'(Q16Ninety);
            end else begin
               x_in   = (-ay) <<< 16;
               y_in   = az <<< 16;
               acc_in = -AccWidth'(Q16Ninety);
            end
         end else begin
            x_in   = az <<< 16;
            y_in   = ay <<< 16;
            acc_in = '0;
         end
      end else if (cmd.rotate) begin
         if (!y_ff[CordicWidth-1]) begin
            x_in   = x_ff + sx;
            y_in   = y_ff - sy;
            acc_in = acc_ff + atan_step;
         end else begin
            x_in   = x_ff - sx;
            y_in   = y_ff + sy;
            acc_in = acc_ff - atan_step;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      y_ff   <= y_in;
      acc_ff <= acc_in;
      if (cmd.load) begin
         zero_ff <= (in_accel_y == 16'sd0) && (in_accel_z == 16'sd0);
      end
   end

   // Round to 1/256 degree and clamp.
   logic signed [AccWidth:0]     acc_rnd;
   logic signed [PitchWidth-1:0] pitch_ff, pitch_calc;

   assign acc_rnd = (AccWidth+1)'(acc_ff) + (AccWidth+1)'(128);

   always_comb begin
      logic signed [AccWidth-8:0] sh;
      sh = (AccWidth-7)'(acc_rnd >>> 8);
      if (zero_ff) begin
         pitch_calc = '0;
      end else if (sh > (AccWidth-7)'(PitchLimit)) begin
         pitch_calc = PitchWidth'(PitchLimit);
      end else if (sh < -(AccWidth-7)'(PitchLimit)) begin
         pitch_calc = -PitchWidth'(PitchLimit);
      end else begin
         pitch_calc = PitchWidth'(sh);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.pitch_done) begin
         pitch_ff <= pitch_calc;
      end
   end

   // ---------------- Calibration sum and error ----------------
   logic signed [SumWidth-1:0]   sum_ff;
   logic signed [SumWidth:0]     sum_add;
   logic signed [PitchWidth-1:0] neutral_ff;
   logic signed [PitchWidth:0]   err_ff;
   logic signed [26:0]           prod_ff;
   logic signed [PitchWidth:0]   err_calc;
   logic signed [17:0]           quot_ff;

   assign sum_add  = (SumWidth+1)'(sum_ff) + (SumWidth+1)'(pitch_ff);
   assign err_calc = (PitchWidth+1)'(pitch_ff) - (PitchWidth+1)'(neutral_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff     <= '0;
         neutral_ff <= '0;
      end else begin
         if (cmd.step && cmd.accumulate) begin
            if (sum_add > (SumWidth+1)'(SumLimit)) begin
               sum_ff <= SumWidth'(SumLimit);
            end else if (sum_add < -(SumWidth+1)'(SumLimit)) begin
               sum_ff <= -SumWidth'(SumLimit);
            end else begin
               sum_ff <= SumWidth'(sum_add);
            end
         end
         if (cmd.set_neutral) begin
            neutral_ff <= PitchWidth'(quot_ff);
         end
      end
      if (cmd.step) begin
         err_ff  <= err_calc;
         prod_ff <= $signed({1'b0, gain_ff}) * err_calc;
      end
   end

   // ---------------- Control law ----------------
   logic [7:0]          angle_ff;
   logic                upd_ff, led_ff;
   logic [PitchWidth:0] mag;
   logic signed [15:0]  delta, delta_c;
   logic signed [26:0]  prod_adj;
   logic signed [8:0]   target, diff;
   logic signed [7:0]   maxd;

   assign mag      = err_ff[PitchWidth] ? (PitchWidth+1)'(-err_ff) : err_ff;
   assign prod_adj = prod_ff[26] ? prod_ff + 27'sd4095 : prod_ff;
   assign delta    = 16'(prod_adj >>> 12);
   assign maxd     = $signed({1'b0, max_delta_ff});

   always_comb begin
      logic signed [15:0] t16;
      if (delta > 16'(maxd)) begin
         delta_c = 16'(maxd);
      end else if (delta < -16'(maxd)) begin
         delta_c = -16'(maxd);
      end else begin
         delta_c = delta;
      end
      // The target can go below zero before the clamp, so compare signed.
      t16 = 16'(Center) + delta_c;
      if (t16 < $signed(16'(AngleLow))) begin
         target = 9'(AngleLow);
      end else if (t16 > $signed(16'(AngleHigh))) begin
         target = 9'(AngleHigh);
      end else begin
         target = 9'(t16);
      end
      diff = target - $signed({1'b0, angle_ff});
      if (diff < 0) begin
         diff = -diff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_ff <= 8'(Center);
      end else if (cmd.control) begin
         if (mag < (PitchWidth+1)'(deadzone_ff)) begin
            if (angle_ff != 8'(Center)) begin
               angle_ff <= 8'(Center);
            end
         end else if (diff >= $signed({2'b0, min_step_ff}) && target[7:0] != angle_ff) begin
            angle_ff <= target[7:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.step) begin
         upd_ff <= 1'b0;
         led_ff <= 1'b0;
      end else if (cmd.control) begin
         if (mag < (PitchWidth+1)'(deadzone_ff)) begin
            upd_ff <= (angle_ff != 8'(Center));
         end else begin
            led_ff <= 1'b1;
            upd_ff <= (diff >= $signed({2'b0, min_step_ff}) && target[7:0] != angle_ff);
         end
      end
   end

   // ---------------- Divide by constant, truncating toward zero ----------------
   logic signed [25:0]         cmul_ff;
   logic signed [16:0]         span;
   logic [SumWidth-1:0]        div_mag, div_mag_ff;
   logic                       div_neg, div_neg_ff;
   logic [RecipWidth-1:0]      recip;
   logic [48:0]                dprod_ff;
   logic [16:0]                q0;
   logic [24:0]                rem, qc;
   logic [7:0]                 divisor;
   logic [16:0]                qfix;

   assign span = $signed({1'b0, pmax_ff}) - $signed({1'b0, pmin_ff});

   always_comb begin
      if (cmd.div_cal) begin
         div_neg = sum_ff[SumWidth-1];
         div_mag = div_neg ? SumWidth'(-sum_ff) : SumWidth'(sum_ff);
         recip   = RecipWidth'(RecipCal);
         divisor = 8'(DivCal);
      end else begin
         div_neg = cmul_ff[25];
         div_mag = div_neg ? SumWidth'(-cmul_ff) : SumWidth'(cmul_ff);
         recip   = RecipWidth'(RecipServo);
         divisor = 8'(DivServo);
      end
      q0   = dprod_ff[48:32];
      qc   = 25'(q0) * 25'(divisor);
      rem  = {1'b0, div_mag_ff} - qc;
      qfix = (rem >= 25'(divisor)) ? q0 + 17'd1 : q0;
   end

   always_ff @(posedge clock) begin
      if (cmd.cmp_mul) begin
         cmul_ff <= $signed({1'b0, angle_ff}) * span;
      end
      if (cmd.div_mul) begin
         div_mag_ff <= div_mag;
         div_neg_ff <= div_neg;
         dprod_ff   <= 49'(div_mag) * 49'(recip);
      end
      if (cmd.div_fix) begin
         quot_ff <= div_neg_ff ? -$signed({1'b0, qfix}) : $signed({1'b0, qfix});
      end
   end

   // ---------------- Compare and result register ----------------
   logic signed [18:0] high, high_c, cmp;

   always_comb begin
      high = $signed({3'b0, pmin_ff}) + 19'(quot_ff);
      if (high < 0) begin
         high_c = '0;
      end else if (high > 19'sd65535) begin
         high_c = 19'sd65535;
      end else begin
         high_c = high;
      end
      cmp = $signed({3'b0, period_ff}) - high_c - 19'sd1;
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_pulse_compare <= cmp[18] ? 16'd0 : cmp[15:0];
         out_servo_update  <= upd_ff;
         out_led_on        <= led_ff;
         out_calibrating   <= cmd.calibrating;
         out_pitch         <= pitch_ff;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/tdsc_checker.sv -----
// Port-level checks for the tilt deadzone servo controller, bound to the top.
// Depends on tdsc_pkg for the pitch width and limit.
`default_nettype none

module tdsc_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                rsp_valid,
   input wire logic                                rsp_ready,
   input wire logic [15:0]                         rsp_pulse_compare,
   input wire logic                                rsp_servo_update,
   input wire logic                                rsp_led_on,
   input wire logic                                rsp_calibrating,
   input wire logic signed [tdsc_pkg::PitchWidth-1:0] rsp_pitch
);
   import tdsc_pkg::*;

   // A stalled result word keeps its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pulse_compare) && $stable(rsp_pitch))
      else $error("result word changed while stalled");

   // Calibration words never drive the LED or move the servo.
   a_cal_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_calibrating |-> !rsp_led_on && !rsp_servo_update)
      else $error("calibration word flagged LED or servo update");

   // Pitch stays within plus or minus 180 degrees.
   a_pitch_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_pitch <= PitchWidth'(PitchLimit)) && (rsp_pitch >= -PitchWidth'(PitchLimit)))
      else $error("pitch out of range");

   // No result is offered right after reset.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind tilt_deadzone_servo_controller_unit tdsc_checker u_tdsc_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_pulse_compare (rsp_ch.pulse_compare),
   .rsp_servo_update  (rsp_ch.servo_update),
   .rsp_led_on        (rsp_ch.led_on),
   .rsp_calibrating   (rsp_ch.calibrating),
   .rsp_pitch         (rsp_ch.pitch)
);

`default_nettype wire
